@@ hw/rtl/ppp_pkg.sv @@
`default_nettype none

package ppp_pkg;

  localparam int COORD_W = 32;
  localparam int REG_W = 64;
  localparam int NCOEF_REG = 6;
  localparam int CFG_IDX_W = 3;
  localparam int SIZE_BITS = 14;
  localparam int PIX_W = 16;
  localparam int RATIO_BITS = 20;
  localparam int PROD_W = RATIO_BITS + SIZE_BITS + 1;
  localparam int VIS_LIMIT = 66;
  localparam int RESET_WIDTH = 1920;
  localparam int RESET_HEIGHT = 1080;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_ROW0_01,
    REG_ROW0_23,
    REG_ROW1_01,
    REG_ROW1_23,
    REG_ROW3_01,
    REG_ROW3_23,
    REG_WIDTH,
    REG_HEIGHT
  } cfg_reg_t;

  typedef struct packed {
    logic                  neg;
    logic                  ovf;
    logic                  rz;
    logic [RATIO_BITS-1:0] quo;
    logic [SIZE_BITS-1:0]  frac;
  } lane_in_t;

endpackage

`default_nettype wire

@@ hw/rtl/perspective_point_projection.sv @@
// Channel   Direction  Handshake              Payload
// config    in         cfg_write              cfg_index, cfg_data
// point     in         in_valid / in_stall    world_x, world_y, world_z
// pixel     out        out_valid / out_stall  visible, screen_x, screen_y
//
// One point is taken every cycle while in_stall is low.
// Each axis runs through a chain of 20 divide cells and 14 scaling cells.
// Reset clears the coefficients and loads the default screen size.
// A stalled output parks one result in a skid register; in_stall is that register's flag.
`default_nettype none

module perspective_point_projection #(
  parameter int COORD_FRAC_BITS = 16
) (
  input  logic                                 clk,
  input  logic                                 rst,
  input  logic                                 cfg_write,
  input  logic        [ppp_pkg::CFG_IDX_W-1:0] cfg_index,
  input  logic        [ppp_pkg::REG_W-1:0]     cfg_data,
  input  logic                                 in_valid,
  output logic                                 in_stall,
  input  logic signed [ppp_pkg::COORD_W-1:0]   world_x,
  input  logic signed [ppp_pkg::COORD_W-1:0]   world_y,
  input  logic signed [ppp_pkg::COORD_W-1:0]   world_z,
  output logic                                 out_valid,
  input  logic                                 out_stall,
  output logic                                 visible,
  output logic signed [ppp_pkg::PIX_W-1:0]     screen_x,
  output logic signed [ppp_pkg::PIX_W-1:0]     screen_y
);
  import ppp_pkg::*;

  localparam int DW = 66 - COORD_FRAC_BITS;
  localparam int NDIV = RATIO_BITS;
  localparam int NFRAC = SIZE_BITS;
  localparam int NST = 3 + NDIV + NFRAC + 2;
  localparam int AW_D = RATIO_BITS + 3;
  localparam int AW_F = DW + RATIO_BITS + 3;

  logic [REG_W-1:0]     coef [NCOEF_REG];
  logic [SIZE_BITS-1:0] width_px;
  logic [SIZE_BITS-1:0] height_px;

  always_ff @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i < NCOEF_REG; i++) begin
        coef[i] <= '0;
      end
      width_px  <= SIZE_BITS'(RESET_WIDTH);
      height_px <= SIZE_BITS'(RESET_HEIGHT);
    end else if (cfg_write) begin
      case (cfg_reg_t'(cfg_index))
        REG_ROW0_01: coef[0] <= cfg_data;
        REG_ROW0_23: coef[1] <= cfg_data;
        REG_ROW1_01: coef[2] <= cfg_data;
        REG_ROW1_23: coef[3] <= cfg_data;
        REG_ROW3_01: coef[4] <= cfg_data;
        REG_ROW3_23: coef[5] <= cfg_data;
        REG_WIDTH:   width_px <= cfg_data[SIZE_BITS-1:0];
        REG_HEIGHT:  height_px <= cfg_data[SIZE_BITS-1:0];
        default: ;
      endcase
    end
  end

  logic [NST-1:0] v;
  logic           adv;
  logic           sk_valid;

  assign adv      = !sk_valid;
  assign in_stall = sk_valid;

  always_ff @(posedge clk) begin
    if (rst) begin
      v <= '0;
    end else if (adv) begin
      v <= {v[NST-2:0], in_valid};
    end
  end

  logic signed [DW-1:0] d0;
  logic signed [DW-1:0] d1;
  logic signed [DW-1:0] dw;

  ppp_dot #(.FRAC(COORD_FRAC_BITS), .DW(DW)) u_dot (
    .clk (clk),
    .en  (adv),
    .x   (world_x),
    .y   (world_y),
    .z   (world_z),
    .coef(coef),
    .d0  (d0),
    .d1  (d1),
    .dw  (dw)
  );

  logic signed [DW-1:0]         dd [2];
  logic        [DW-1:0]         mag [2];
  logic        [DW-1:0]         c_hi [2];
  logic        [RATIO_BITS-1:0] c_lo [2];
  logic                         c_neg [2];
  logic                         c_ovf [2];
  logic        [DW-1:0]         c_w;
  logic                         c_vis;

  assign dd[0] = d0;
  assign dd[1] = d1;

  always_comb begin
    for (int l = 0; l < 2; l++) begin
      mag[l] = dd[l][DW-1] ? DW'(-dd[l]) : DW'(dd[l]);
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      for (int l = 0; l < 2; l++) begin
        c_hi[l]  <= mag[l] >> RATIO_BITS;
        c_lo[l]  <= mag[l][RATIO_BITS-1:0];
        c_neg[l] <= dd[l][DW-1];
        c_ovf[l] <= {{RATIO_BITS{1'b0}}, mag[l]} >= {dw, {RATIO_BITS{1'b0}}};
      end
      c_w   <= dw;
      c_vis <= dw > $signed(DW'(VIS_LIMIT));
    end
  end

  logic [SIZE_BITS-1:0] lsz [2];
  lane_in_t [1:0]       lane_in;
  logic                 lane_vis [2];

  assign lsz[0] = width_px;
  assign lsz[1] = height_px;

  for (genvar l = 0; l < 2; l++) begin : g_lane
    logic [DW-1:0]         dr  [NDIV];
    logic [DW-1:0]         dwv [NDIV];
    logic [RATIO_BITS-1:0] dq  [NDIV];
    logic [AW_D-1:0]       dx  [NDIV];
    logic [DW-1:0]         fr  [NFRAC];
    logic [DW-1:0]         fwv [NFRAC];
    logic [SIZE_BITS:0]    fq  [NFRAC];
    logic [AW_F-1:0]       fx  [NFRAC];

    for (genvar j = 0; j < NDIV; j++) begin : g_div
      logic [DW-1:0]         pr;
      logic [DW-1:0]         pw;
      logic [DW-1:0]         padd;
      logic [RATIO_BITS-1:0] pq;
      logic [AW_D-1:0]       px;
      if (j == 0) begin : g_first
        assign pr = c_hi[l];
        assign pw = c_w;
        assign pq = '0;
        assign px = {c_vis, c_ovf[l], c_neg[l], c_lo[l]};
      end else begin : g_next
        assign pr = dr[j-1];
        assign pw = dwv[j-1];
        assign pq = dq[j-1];
        assign px = dx[j-1];
      end
      assign padd = DW'(px[RATIO_BITS-1-j]);

      ppp_cell #(.RW(DW), .QW(RATIO_BITS), .AW(AW_D)) u_cell (
        .clk   (clk),
        .en    (adv),
        .in_r  (pr),
        .in_w  (pw),
        .in_add(padd),
        .in_q  (pq),
        .in_aux(px),
        .r     (dr[j]),
        .w     (dwv[j]),
        .q     (dq[j]),
        .aux   (dx[j])
      );
    end

    for (genvar j = 0; j < NFRAC; j++) begin : g_frac
      logic [DW-1:0]      pr;
      logic [DW-1:0]      pw;
      logic [DW-1:0]      padd;
      logic [SIZE_BITS:0] pq;
      logic [AW_F-1:0]    px;
      if (j == 0) begin : g_first
        assign pr = '0;
        assign pw = dwv[NDIV-1];
        assign pq = '0;
        assign px = {dx[NDIV-1][AW_D-1:RATIO_BITS], dq[NDIV-1], dr[NDIV-1]};
      end else begin : g_next
        assign pr = fr[j-1];
        assign pw = fwv[j-1];
        assign pq = fq[j-1];
        assign px = fx[j-1];
      end
      assign padd = lsz[l][SIZE_BITS-1-j] ? px[DW-1:0] : '0;

      ppp_cell #(.RW(DW), .QW(SIZE_BITS + 1), .AW(AW_F)) u_cell (
        .clk   (clk),
        .en    (adv),
        .in_r  (pr),
        .in_w  (pw),
        .in_add(padd),
        .in_q  (pq),
        .in_aux(px),
        .r     (fr[j]),
        .w     (fwv[j]),
        .q     (fq[j]),
        .aux   (fx[j])
      );
    end

    assign lane_in[l].neg  = fx[NFRAC-1][DW+RATIO_BITS];
    assign lane_in[l].ovf  = fx[NFRAC-1][DW+RATIO_BITS+1];
    assign lane_in[l].rz   = (fr[NFRAC-1] == '0);
    assign lane_in[l].quo  = fx[NFRAC-1][DW +: RATIO_BITS];
    assign lane_in[l].frac = fq[NFRAC-1][SIZE_BITS-1:0];
    assign lane_vis[l]     = fx[NFRAC-1][DW+RATIO_BITS+2];
  end

  logic                     p_vis;
  logic signed [PIX_W-1:0]  p_x;
  logic signed [PIX_W-1:0]  p_y;

  ppp_post u_post (
    .clk      (clk),
    .en       (adv),
    .width_px (width_px),
    .height_px(height_px),
    .vis      (lane_vis[0]),
    .lane     (lane_in),
    .visible  (p_vis),
    .screen_x (p_x),
    .screen_y (p_y)
  );

  logic                    push;
  logic                    sk_vis;
  logic signed [PIX_W-1:0] sk_x;
  logic signed [PIX_W-1:0] sk_y;

  assign push = adv && v[NST-1];

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
      sk_valid  <= 1'b0;
    end else if (!out_valid || !out_stall) begin
      if (sk_valid) begin
        out_valid <= 1'b1;
        sk_valid  <= 1'b0;
      end else begin
        out_valid <= push;
      end
    end else if (push) begin
      sk_valid <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!out_valid || !out_stall) begin
      if (sk_valid) begin
        visible  <= sk_vis;
        screen_x <= sk_x;
        screen_y <= sk_y;
      end else begin
        visible  <= p_vis;
        screen_x <= p_x;
        screen_y <= p_y;
      end
    end else if (push) begin
      sk_vis <= p_vis;
      sk_x   <= p_x;
      sk_y   <= p_y;
    end
  end

`ifndef SYNTH
  a_hidden_zero: assert property (@(posedge clk) disable iff (rst)
    out_valid && !visible |-> (screen_x == '0) && (screen_y == '0))
    else $error("hidden point with nonzero pixel");

  a_skid_only_behind_output: assert property (@(posedge clk) disable iff (rst)
    in_stall |-> out_valid)
    else $error("skid holds a result while the output is empty");

  a_accept_enters: assert property (@(posedge clk) disable iff (rst)
    in_valid && !in_stall |=> v[0])
    else $error("accepted point did not enter the pipeline");

  a_frozen_when_full: assert property (@(posedge clk) disable iff (rst)
    in_stall |=> $stable(v))
    else $error("pipeline moved while the skid was full");
`endif

endmodule

`default_nettype wire

@@ hw/rtl/ppp_cell.sv @@
`default_nettype none

module ppp_cell #(
  parameter int RW = 50,
  parameter int QW = 20,
  parameter int AW = 23
) (
  input  logic          clk,
  input  logic          en,
  input  logic [RW-1:0] in_r,
  input  logic [RW-1:0] in_w,
  input  logic [RW-1:0] in_add,
  input  logic [QW-1:0] in_q,
  input  logic [AW-1:0] in_aux,
  output logic [RW-1:0] r,
  output logic [RW-1:0] w,
  output logic [QW-1:0] q,
  output logic [AW-1:0] aux
);

  logic [RW+1:0] t;
  logic [RW+1:0] w1;
  logic [RW+1:0] w2;
  logic [RW-1:0] r_next;
  logic [1:0]    c;
  logic [QW-1:0] q_next;

  always_comb begin
    t  = {1'b0, in_r, 1'b0} + {2'b00, in_add};
    w1 = {2'b00, in_w};
    w2 = {1'b0, in_w, 1'b0};
    if (t >= w2) begin
      c      = 2'd2;
      r_next = RW'(t - w2);
    end else if (t >= w1) begin
      c      = 2'd1;
      r_next = RW'(t - w1);
    end else begin
      c      = 2'd0;
      r_next = RW'(t);
    end
    q_next = {in_q[QW-2:0], 1'b0} + QW'(c);
  end

  always_ff @(posedge clk) begin
    if (en) begin
      r   <= r_next;
      w   <= in_w;
      q   <= q_next;
      aux <= in_aux;
    end
  end

endmodule

`default_nettype wire

@@ hw/rtl/ppp_dot.sv @@
`default_nettype none

module ppp_dot #(
  parameter int FRAC = 16,
  parameter int DW = 50
) (
  input  logic                                 clk,
  input  logic                                 en,
  input  logic signed [ppp_pkg::COORD_W-1:0]   x,
  input  logic signed [ppp_pkg::COORD_W-1:0]   y,
  input  logic signed [ppp_pkg::COORD_W-1:0]   z,
  input  logic        [ppp_pkg::REG_W-1:0]     coef [ppp_pkg::NCOEF_REG],
  output logic signed [DW-1:0]                 d0,
  output logic signed [DW-1:0]                 d1,
  output logic signed [DW-1:0]                 dw
);
  import ppp_pkg::*;

  localparam int NROW = NCOEF_REG / 2;
  localparam int PW = 2 * COORD_W;

  logic signed [PW-1:0] prod [NROW][3];
  logic signed [DW-1:0] s [NROW];

  always_ff @(posedge clk) begin
    if (en) begin
      for (int r = 0; r < NROW; r++) begin
        prod[r][0] <= $signed(coef[2*r][COORD_W-1:0]) * x;
        prod[r][1] <= $signed(coef[2*r][REG_W-1:COORD_W]) * y;
        prod[r][2] <= $signed(coef[2*r+1][COORD_W-1:0]) * z;
      end
    end
  end

  always_comb begin
    for (int r = 0; r < NROW; r++) begin
      s[r] = DW'(prod[r][0] >>> FRAC) + DW'(prod[r][1] >>> FRAC)
           + DW'(prod[r][2] >>> FRAC) + DW'($signed(coef[2*r+1][REG_W-1:COORD_W]));
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      d0 <= s[0];
      d1 <= s[1];
      dw <= s[2];
    end
  end

endmodule

`default_nettype wire

@@ hw/rtl/ppp_post.sv @@
`default_nettype none

module ppp_post (
  input  logic                                 clk,
  input  logic                                 en,
  input  logic        [ppp_pkg::SIZE_BITS-1:0] width_px,
  input  logic        [ppp_pkg::SIZE_BITS-1:0] height_px,
  input  logic                                 vis,
  input  ppp_pkg::lane_in_t [1:0]              lane,
  output logic                                 visible,
  output logic signed [ppp_pkg::PIX_W-1:0]     screen_x,
  output logic signed [ppp_pkg::PIX_W-1:0]     screen_y
);
  import ppp_pkg::*;

  localparam int FW = PROD_W + 5;
  localparam logic signed [FW-1:0] LIM = FW'(1) <<< RATIO_BITS;
  localparam logic signed [FW-1:0] PMAX = (FW'(1) <<< (PIX_W - 1)) - FW'(1);
  localparam logic signed [FW-1:0] PMIN = -PMAX - FW'(1);

  logic [SIZE_BITS-1:0] sz [2];
  logic [PROD_W-1:0]    pm [2];
  logic                 rz_m [2];
  logic                 neg_m [2];
  logic                 ovf_m [2];
  logic                 vis_m;

  assign sz[0] = width_px;
  assign sz[1] = height_px;

  function automatic logic signed [PIX_W-1:0] pix(
    input logic [PROD_W-1:0]    p,
    input logic                 rz,
    input logic                 neg_d,
    input logic                 ovf,
    input logic [SIZE_BITS-1:0] s,
    input logic                 flip
  );
    logic signed [FW-1:0] pe;
    logic signed [FW-1:0] k;
    logic signed [FW-1:0] fl;
    logic signed [FW-1:0] base;
    logic signed [FW-1:0] v;
    logic                 ex;
    pe   = $signed(FW'(p));
    base = $signed(FW'(s >> 1));
    k    = '0;
    ex   = 1'b0;
    if (flip) begin
      base = -base;
    end
    if (ovf && (s != '0)) begin
      fl = neg_d ? -LIM : LIM;
    end else begin
      if (!neg_d) begin
        k  = pe + FW'(1);
        ex = rz;
      end else if (rz) begin
        k  = FW'(1) - pe;
        ex = 1'b1;
      end else begin
        k  = -pe;
        ex = 1'b0;
      end
      fl = base + (k >>> 1);
      if ((fl < 0) && !(ex && !k[0])) begin
        fl = fl + FW'(1);
      end
    end
    v = flip ? -fl : fl;
    if (v > PMAX) begin
      v = PMAX;
    end else if (v < PMIN) begin
      v = PMIN;
    end
    return v[PIX_W-1:0];
  endfunction

  always_ff @(posedge clk) begin
    if (en) begin
      for (int l = 0; l < 2; l++) begin
        pm[l]    <= PROD_W'(lane[l].quo) * PROD_W'(sz[l]) + PROD_W'(lane[l].frac);
        rz_m[l]  <= lane[l].rz;
        neg_m[l] <= lane[l].neg;
        ovf_m[l] <= lane[l].ovf;
      end
      vis_m <= vis;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      visible  <= vis_m;
      screen_x <= vis_m ? pix(pm[0], rz_m[0], neg_m[0], ovf_m[0], sz[0], 1'b0) : '0;
      screen_y <= vis_m ? pix(pm[1], rz_m[1], neg_m[1], ovf_m[1], sz[1], 1'b1) : '0;
    end
  end

endmodule

`default_nettype wire
